// ===== design/lpc_pkg.sv =====
// Shared types and constants for the light level PI controller.
// No dependencies; used by lpc_update and light_pi_controller.
`default_nettype none

package lpc_pkg;

   // Configuration register indexes.
   localparam logic CSR_TARGET_LEVEL = 1'b0;
   localparam logic CSR_MANUAL_MODE  = 1'b1;

   localparam int LEVEL_W = 7;
   localparam int ERR_W   = 8;
   localparam int INTEG_W = 16;
   localparam int NUM_W   = 19;

   localparam logic [LEVEL_W-1:0] TARGET_RESET = 7'd50;
   localparam logic [LEVEL_W-1:0] DRIVE_MAX    = 7'd100;

   // Integral limit 1000.0 in Q10.6.
   localparam logic [INTEG_W-1:0] INTEG_MAX_Q6 = 16'd64000;
   // Separation band: the error enters the integral only when |error| < 35.
   localparam logic signed [ERR_W-1:0] SEP_LIMIT = 8'sd35;
   // Drive saturates once num reaches (DRIVE_MAX + 1) * 640.
   localparam logic signed [NUM_W-1:0] DRIVE_SAT_NUM = 19'sd64640;
   // floor(x / 5) = (x * 205) >> 10 for x below 1024.
   localparam logic [7:0] RECIP_FIVE = 8'd205;

   typedef struct packed {
      logic [LEVEL_W-1:0] light_level;
      logic [LEVEL_W-1:0] present_brightness;
   } req_type;

   typedef struct packed {
      logic               drive_valid;
      logic [LEVEL_W-1:0] led_drive;
   } rsp_type;

   typedef struct packed {
      logic [INTEG_W-1:0]      integral_sum;
      logic signed [ERR_W-1:0] previous_error;
   } state_type;

endpackage

`default_nettype wire

// ===== design/light_pi_controller.sv =====
// Top level of the light level PI controller: request and result registers,
// controller state and configuration registers. Depends on lpc_pkg, lpc_update.
//
// Usage: each request on req_ carries a light sample and the LED brightness now
// applied. Every request yields exactly one result on rsp_: in automatic mode
// rsp_drive_valid is 1 and rsp_led_drive is the new brightness command; in
// manual mode both are zero while the integral tracks the brightness.
// An accepted request is held in the request register and its result in the
// result register. Throughput is one request per cycle while rsp_ready is high:
// the update of the integral and the previous error is one short combinational
// step between the two registers, so requests may follow back to back.
// When the receiver stalls (rsp_ready low), the result register holds and the
// request register fills; req_ready drops only when both are occupied.
// Synchronous reset empties both registers, clears the integral and the
// previous error, and sets target_level to 50 and manual_mode to automatic.
// csr_ writes take effect at the next edge; write them only while idle.
`default_nettype none

module light_pi_controller (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [lpc_pkg::LEVEL_W-1:0] req_light_level,
   input  logic [lpc_pkg::LEVEL_W-1:0] req_present_brightness,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_drive_valid,
   output logic [lpc_pkg::LEVEL_W-1:0] rsp_led_drive,
   input  logic                        csr_write_en,
   input  logic                        csr_index,
   input  logic [lpc_pkg::LEVEL_W-1:0] csr_wdata
);
   import lpc_pkg::*;

   logic               s1_valid_ff, s1_valid_in;
   req_type            s1_req_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff;
   state_type          state_ff;
   logic [LEVEL_W-1:0] target_level_ff;
   logic               manual_mode_ff;

   logic      advance;
   logic      req_fire;
   state_type state_next;
   rsp_type   rsp_next;

   lpc_update u_update (
      .state_cur    (state_ff),
      .req_item     (s1_req_ff),
      .target_level (target_level_ff),
      .manual_mode  (manual_mode_ff),
      .state_next   (state_next),
      .rsp_item     (rsp_next)
   );

   always_comb begin
      advance      = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
      req_ready    = !s1_valid_ff || advance;
      req_fire     = req_valid && req_ready;
      s1_valid_in  = req_fire || (s1_valid_ff && !advance);
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         state_ff        <= '0;
         target_level_ff <= TARGET_RESET;
         manual_mode_ff  <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_next;
         end
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_TARGET_LEVEL: target_level_ff <= csr_wdata;
               CSR_MANUAL_MODE:  manual_mode_ff  <= csr_wdata[0];
               default:          ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_req_ff.light_level        <= req_light_level;
         s1_req_ff.present_brightness <= req_present_brightness;
      end
      if (advance) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_drive_valid = rsp_ff.drive_valid;
   assign rsp_led_drive   = rsp_ff.led_drive;

   a_integral_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.integral_sum <= INTEG_MAX_Q6)
      else $error("integral left its clamp range");

   a_drive_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.led_drive <= DRIVE_MAX) &&
                       (rsp_ff.drive_valid || (rsp_ff.led_drive == '0)))
      else $error("drive out of range or nonzero without drive_valid");

   a_manual_clears_error: assert property (@(posedge clock) disable iff (reset)
      (advance && manual_mode_ff) |=> (state_ff.previous_error == '0))
      else $error("manual update did not clear the previous error");

   a_stall_holds_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_ff)))
      else $error("stalled result was lost or changed");

endmodule

`default_nettype wire

// ===== design/lpc_update.sv =====
// One-step update of the PI controller: next integral, next error and drive.
// Purely combinational; depends on lpc_pkg.
`default_nettype none

module lpc_update (
   input  lpc_pkg::state_type            state_cur,
   input  lpc_pkg::req_type              req_item,
   input  logic [lpc_pkg::LEVEL_W-1:0]   target_level,
   input  logic                          manual_mode,
   output lpc_pkg::state_type            state_next,
   output lpc_pkg::rsp_type              rsp_item
);
   import lpc_pkg::*;

   logic signed [ERR_W-1:0]   err;
   logic                      sign_flip;
   logic                      in_band;
   logic [INTEG_W-1:0]        halved;
   logic signed [INTEG_W+1:0] err_q6;
   logic signed [INTEG_W+1:0] acc_sum;
   logic [INTEG_W-1:0]        acc_clamped;
   logic signed [NUM_W-1:0]   err_w;
   logic signed [NUM_W-1:0]   num;
   logic [16:0]               quot_prod;
   logic [LEVEL_W-1:0]        drive;
   logic [INTEG_W-1:0]        track;

   always_comb begin
      err = signed'({1'b0, target_level}) - signed'({1'b0, req_item.light_level});

      sign_flip = ((err < 0) && (state_cur.previous_error > 0)) ||
                  ((err > 0) && (state_cur.previous_error < 0));
      halved = sign_flip ? (state_cur.integral_sum >> 1) : state_cur.integral_sum;

      in_band = (err > -SEP_LIMIT) && (err < SEP_LIMIT);
      err_q6  = {{4{err[ERR_W-1]}}, err, 6'b000000};
      acc_sum = signed'({2'b00, halved}) + (in_band ? err_q6 : '0);

      if (acc_sum < 0) begin
         acc_clamped = '0;
      end else if (acc_sum > signed'({2'b00, INTEG_MAX_Q6})) begin
         acc_clamped = INTEG_MAX_Q6;
      end else begin
         acc_clamped = acc_sum[INTEG_W-1:0];
      end

      // Proportional gain 0.6 and integral gain 0.1 share the divisor 640:
      // num = 384 * err + integral_q6.
      err_w = {{(NUM_W-ERR_W){err[ERR_W-1]}}, err};
      num   = signed'({3'b000, acc_clamped}) + (err_w <<< 8) + (err_w <<< 7);

      // Below saturation num < 64640, so num >> 7 stays under 505.
      quot_prod = 17'(num[15:7] * RECIP_FIVE);
      if (num <= 0) begin
         drive = '0;
      end else if (num >= DRIVE_SAT_NUM) begin
         drive = DRIVE_MAX;
      end else begin
         drive = quot_prod[16:10];
      end

      if (req_item.present_brightness > DRIVE_MAX) begin
         track = INTEG_MAX_Q6;
      end else begin
         track = {req_item.present_brightness, 9'b0} +
                 {2'b00, req_item.present_brightness, 7'b0};
      end

      if (manual_mode) begin
         state_next.integral_sum   = track;
         state_next.previous_error = '0;
         rsp_item.drive_valid      = 1'b0;
         rsp_item.led_drive        = '0;
      end else begin
         state_next.integral_sum   = acc_clamped;
         state_next.previous_error = err;
         rsp_item.drive_valid      = 1'b1;
         rsp_item.led_drive        = drive;
      end
   end

endmodule

`default_nettype wire

// ===== tb/light_pi_controller_test.sv =====
// Self-checking testbench for light_pi_controller: a directed table, then random phases.
// Each drive result is checked against its table row or prediction. Depends on lpc_pkg.
module light_pi_controller_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LEVEL_TOP        = 127;
   localparam int INTEGRAL_CEILING = 64000;
   localparam int SEPARATION       = 35;
   localparam int DRIVE_CEILING    = 100;
   localparam int RANDOM_REQUESTS  = 1700;
   localparam int HOLD_OFF_CYCLES  = 64;
   localparam int STALL_LIMIT      = 2000;
   localparam int DRAIN_CYCLES     = 8;

   typedef enum logic {
      MODE_AUTO   = 1'b0,
      MODE_MANUAL = 1'b1
   } mode_type;

   typedef struct packed {
      logic [6:0] level;
      mode_type   mode;
      logic [6:0] light;
      logic [6:0] bright;
      logic       typed;
      logic       drive_valid;
      logic [6:0] led_drive;
   } vector_type;

   localparam int DIRECTED_COUNT = 23;
   localparam vector_type DIRECTED [DIRECTED_COUNT] = '{
      '{7'd50,  MODE_AUTO,   7'd50,  7'd0,   1'b1, 1'b1, 7'd0},
      '{7'd50,  MODE_AUTO,   7'd0,   7'd127, 1'b1, 1'b1, 7'd30},
      '{7'd50,  MODE_AUTO,   7'd100, 7'd0,   1'b1, 1'b1, 7'd0},
      '{7'd127, MODE_AUTO,   7'd0,   7'd0,   1'b1, 1'b1, 7'd76},
      '{7'd127, MODE_AUTO,   7'd127, 7'd127, 1'b1, 1'b1, 7'd0},
      '{7'd0,   MODE_AUTO,   7'd127, 7'd0,   1'b1, 1'b1, 7'd0},
      '{7'd0,   MODE_MANUAL, 7'd0,   7'd127, 1'b1, 1'b0, 7'd0},
      '{7'd0,   MODE_MANUAL, 7'd127, 7'd101, 1'b1, 1'b0, 7'd0},
      '{7'd0,   MODE_MANUAL, 7'd85,  7'd100, 1'b1, 1'b0, 7'd0},
      '{7'd0,   MODE_AUTO,   7'd0,   7'd0,   1'b0, 1'b0, 7'd0},
      '{7'd60,  MODE_AUTO,   7'd30,  7'd0,   1'b0, 1'b0, 7'd0},
      '{7'd60,  MODE_AUTO,   7'd26,  7'd0,   1'b0, 1'b0, 7'd0},
      '{7'd60,  MODE_AUTO,   7'd25,  7'd0,   1'b0, 1'b0, 7'd0},
      '{7'd60,  MODE_AUTO,   7'd95,  7'd0,   1'b0, 1'b0, 7'd0},
      '{7'd60,  MODE_AUTO,   7'd94,  7'd0,   1'b0, 1'b0, 7'd0},
      '{7'd60,  MODE_AUTO,   7'd60,  7'd0,   1'b0, 1'b0, 7'd0},
      '{7'd60,  MODE_AUTO,   7'd61,  7'd0,   1'b0, 1'b0, 7'd0},
      '{7'd60,  MODE_AUTO,   7'd59,  7'd0,   1'b0, 1'b0, 7'd0},
      '{7'd100, MODE_AUTO,   7'd100, 7'd0,   1'b0, 1'b0, 7'd0},
      '{7'd100, MODE_AUTO,   7'd127, 7'd0,   1'b0, 1'b0, 7'd0},
      '{7'd0,   MODE_MANUAL, 7'd3,   7'd1,   1'b1, 1'b0, 7'd0},
      '{7'd0,   MODE_AUTO,   7'd1,   7'd0,   1'b0, 1'b0, 7'd0},
      '{7'd0,   MODE_AUTO,   7'd0,   7'd0,   1'b0, 1'b0, 7'd0}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [lpc_pkg::LEVEL_W-1:0] req_light_level = '0;
   logic [lpc_pkg::LEVEL_W-1:0] req_present_brightness = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_drive_valid;
   logic [lpc_pkg::LEVEL_W-1:0] rsp_led_drive;
   logic csr_write_en = 1'b0;
   logic csr_index = lpc_pkg::CSR_TARGET_LEVEL;
   logic [lpc_pkg::LEVEL_W-1:0] csr_wdata = '0;

   // Mirror of the controller state and settings.
   lpc_pkg::state_type loop_state = '0;
   logic [6:0] target_setting = 7'd50;
   mode_type mode_setting = MODE_AUTO;

   lpc_pkg::rsp_type pending_drives[$];
   int mismatch_count = 0;
   int results_seen = 0;
   int idle_cycles = 0;
   bit req_burst = 1'b0;
   bit rsp_burst = 1'b0;

   light_pi_controller DUT (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_light_level        (req_light_level),
      .req_present_brightness (req_present_brightness),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_drive_valid        (rsp_drive_valid),
      .rsp_led_drive          (rsp_led_drive),
      .csr_write_en           (csr_write_en),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Advances the mirrored state by one request and returns the drive it yields.
   function automatic lpc_pkg::rsp_type predict_drive(input logic [6:0] light,
                                                      input logic [6:0] bright);
      lpc_pkg::rsp_type result;
      int err;
      int last_err;
      int acc;
      int num;
      int drive;
      result = '0;
      if (mode_setting == MODE_MANUAL) begin
         acc = int'(bright) * 640;
         if (acc > INTEGRAL_CEILING) acc = INTEGRAL_CEILING;
         loop_state.integral_sum = 16'(acc);
         loop_state.previous_error = '0;
         return result;
      end
      err = int'(target_setting) - int'(light);
      last_err = int'($signed(loop_state.previous_error));
      acc = int'(loop_state.integral_sum);
      // Fast unwinding: a sign flip of the error halves the integral.
      if ((err < 0 && last_err > 0) || (err > 0 && last_err < 0)) acc = acc / 2;
      if (err > -SEPARATION && err < SEPARATION) acc += err * 64;
      if (acc > INTEGRAL_CEILING) acc = INTEGRAL_CEILING;
      if (acc < 0) acc = 0;
      loop_state.integral_sum = 16'(acc);
      loop_state.previous_error = 8'(err);
      num = 384 * err + acc;
      if (num <= 0) begin
         drive = 0;
      end else begin
         drive = num / 640;
         if (drive > DRIVE_CEILING) drive = DRIVE_CEILING;
      end
      result.drive_valid = 1'b1;
      result.led_drive = 7'(drive);
      return result;
   endfunction

   // Offers one request and, once accepted, queues the drive it should produce.
   task automatic send_request(input logic [6:0] light, input logic [6:0] bright,
                               input bit typed, input lpc_pkg::rsp_type typed_drive);
      int gap;
      lpc_pkg::rsp_type predicted;
      gap = req_burst ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_light_level <= light;
      req_present_brightness <= bright;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = predict_drive(light, bright);
      pending_drives.push_back(typed ? typed_drive : predicted);
   endtask

   // Writes both registers once the controller has nothing in flight.
   task automatic apply_settings(input logic [6:0] level, input mode_type mode);
      req_valid <= 1'b0;
      while (pending_drives.size() != 0) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= lpc_pkg::CSR_TARGET_LEVEL;
      csr_wdata <= level;
      @(posedge clock);
      csr_index <= lpc_pkg::CSR_MANUAL_MODE;
      csr_wdata <= {6'd0, mode};
      @(posedge clock);
      csr_write_en <= 1'b0;
      target_setting = level;
      mode_setting = mode;
   endtask

   initial begin : request_source
      int row;
      int sent;
      int span;
      int light;
      logic [6:0] level;
      mode_type mode;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (row = 0; row < DIRECTED_COUNT; row++) begin
         if (DIRECTED[row].level != target_setting || DIRECTED[row].mode != mode_setting) begin
            apply_settings(DIRECTED[row].level, DIRECTED[row].mode);
         end
         send_request(DIRECTED[row].light, DIRECTED[row].bright, DIRECTED[row].typed,
                      '{DIRECTED[row].drive_valid, DIRECTED[row].led_drive});
      end
      sent = 0;
      while (sent < RANDOM_REQUESTS) begin
         case ($urandom_range(0, 5))
            0: begin
               level = 7'd0;
            end
            1: begin
               level = 7'd127;
            end
            2: begin
               level = 7'd100;
            end
            3: begin
               level = 7'($urandom_range(0, LEVEL_TOP));
            end
            default: begin
               level = 7'($urandom_range(0, DRIVE_CEILING));
            end
         endcase
         mode = ($urandom_range(0, 4) == 0) ? MODE_MANUAL : MODE_AUTO;
         apply_settings(level, mode);
         req_burst = ($urandom_range(0, 3) == 0);
         rsp_burst = ($urandom_range(0, 3) == 0);
         span = $urandom_range(10, 80);
         repeat (span) begin
            // Mostly hover near the target so the integral band and sign flips get exercised.
            if ($urandom_range(0, 9) < 7) begin
               light = int'(level) + int'($urandom_range(0, 80)) - 40;
               if (light < 0) light = 0;
               if (light > LEVEL_TOP) light = LEVEL_TOP;
            end else begin
               light = $urandom_range(0, LEVEL_TOP);
            end
            send_request(7'(light), 7'($urandom_range(0, LEVEL_TOP)), 1'b0, '0);
            sent++;
         end
      end
      req_valid <= 1'b0;
      while (pending_drives.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin : result_sink
      int stall;
      lpc_pkg::rsp_type want;
      while (reset) @(posedge clock);
      forever begin
         stall = rsp_burst ? 0 : $urandom_range(0, 9);
         // A long hold-off now and then lets the request side back up.
         if (results_seen % 500 == 250) stall = HOLD_OFF_CYCLES;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         results_seen++;
         if (pending_drives.size() == 0) begin
            if (mismatch_count < 10) begin
               $display("result %0d arrived with no request outstanding", results_seen);
            end
            mismatch_count++;
         end else begin
            want = pending_drives.pop_front();
            if (rsp_drive_valid !== want.drive_valid || rsp_led_drive !== want.led_drive) begin
               if (mismatch_count < 10) begin
                  $display({"result %0d: drive_valid expected %0b got %0b, ",
                            "led_drive expected %0d got %0d"},
                           results_seen, want.drive_valid, rsp_drive_valid,
                           want.led_drive, rsp_led_drive);
               end
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_en) begin
         idle_cycles = 0;
      end else begin
         idle_cycles = idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

endmodule
